// File: hdl/sobel_pkg.sv
package sobel_pkg;

   localparam int PIXEL_W      = 8;
   localparam int WIDTH_REG_W  = 12;
   localparam int HEIGHT_REG_W = 13;
   localparam int CSR_DATA_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int MAG_W        = 8;
   localparam int OUT_ROW_W    = 12;
   localparam int OUT_COL_W    = 11;
   localparam int REQ_TDATA_W  = 8;
   localparam int RSP_TDATA_W  = 32;

   // gradient range is -1020..1020, squares summed stay below 2**21
   localparam int GRAD_W       = 11;
   localparam int SUM_W        = 21;
   localparam int SUM_MAX      = 2080800;
   localparam int SAT_LIMIT    = 65536;
   localparam int ROOT_STEPS   = 8;
   localparam int STEP_W       = 3;

   localparam logic [MAG_W-1:0]        MAG_MAX      = 8'd255;
   localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
   localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

   typedef struct packed {
      logic              accept;
      logic              shift;
      logic              grad;
      logic              sq_x;
      logic              sq_y;
      logic              root_step;
      logic [STEP_W-1:0] root_bit;
      logic              load_out;
   } sobel_cmd_type;

endpackage

// File: hdl/sobel_dp.sv
module sobel_dp import sobel_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [PIXEL_W-1:0]     pixel_value,
   input  sobel_cmd_type          cmd,
   output logic                   item_emit,
   output logic [MAG_W-1:0]       edge_magnitude,
   output logic [OUT_ROW_W-1:0]   out_row,
   output logic [OUT_COL_W-1:0]   out_col,
   output logic                   frame_last
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);

   logic [WIDTH_REG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_REG_W-1:0] height_ff, height_in;
   logic [CW-1:0]           col_ff, col_in;
   logic [RW-1:0]           row_ff, row_in;
   logic [CW-1:0]           last_col;
   logic [RW-1:0]           last_row;

   logic [PIXEL_W-1:0]      px_ff;
   logic [CW-1:0]           icol_ff;
   logic [RW-1:0]           irow_ff;
   logic                    emit_ff;
   logic                    ilast_ff;

   logic [PIXEL_W-1:0]      older_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0]      newer_mem [MAX_WIDTH];
   logic [PIXEL_W-1:0]      top_rd_ff;
   logic [PIXEL_W-1:0]      mid_rd_ff;

   logic [PIXEL_W-1:0]      taps_ff [3][3];

   logic [GRAD_W-1:0]       pos_x, neg_x, pos_y, neg_y;
   logic signed [GRAD_W-1:0] gx_ff, gy_ff;
   logic signed [2*GRAD_W-1:0] sq_op;
   logic signed [2*GRAD_W-1:0] sq_prod;
   logic [SUM_W-1:0]        sum_ff;
   logic [MAG_W-1:0]        root_ff;
   logic [MAG_W-1:0]        trial;
   logic [2*MAG_W-1:0]      trial_sq;

   logic [MAG_W-1:0]        mag_ff;
   logic [OUT_ROW_W-1:0]    row_out_ff;
   logic [OUT_COL_W-1:0]    col_out_ff;
   logic                    last_out_ff;

   // effective frame size, held in 3..MAX
   always_comb begin
      if (width_ff < 12'd3) begin
         last_col = CW'(2);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         last_col = CW'(MAX_WIDTH - 1);
      end else begin
         last_col = CW'(width_ff - 12'd1);
      end
      if (height_ff < 13'd3) begin
         last_row = RW'(2);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         last_row = RW'(MAX_HEIGHT - 1);
      end else begin
         last_row = RW'(height_ff - 13'd1);
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_REG_W-1:0];
            default: ;
         endcase
         // any write restarts the frame
         col_in = '0;
         row_in = '0;
      end else if (cmd.accept) begin
         if (col_ff == last_col) begin
            col_in = '0;
            row_in = (row_ff == last_row) ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b0;
      end else if (cmd.accept) begin
         emit_ff <= (col_ff >= CW'(2)) && (row_ff >= RW'(2));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         px_ff    <= pixel_value;
         icol_ff  <= col_ff;
         irow_ff  <= row_ff;
         ilast_ff <= (col_ff == last_col) && (row_ff == last_row);
      end
   end

   // line stores: read on transfer, write back the shifted column in the cycle after
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         top_rd_ff <= older_mem[col_ff];
         mid_rd_ff <= newer_mem[col_ff];
      end
      if (cmd.shift) begin
         older_mem[icol_ff] <= mid_rd_ff;
         newer_mem[icol_ff] <= px_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int j = 0; j < 3; j++) begin
               taps_ff[k][j] <= '0;
            end
         end
      end else if (cmd.shift) begin
         for (int k = 0; k < 3; k++) begin
            taps_ff[k][0] <= taps_ff[k][1];
            taps_ff[k][1] <= taps_ff[k][2];
         end
         taps_ff[0][2] <= top_rd_ff;
         taps_ff[1][2] <= mid_rd_ff;
         taps_ff[2][2] <= px_ff;
      end
   end

   assign pos_x = GRAD_W'(taps_ff[0][2]) + GRAD_W'({taps_ff[1][2], 1'b0})
                  + GRAD_W'(taps_ff[2][2]);
   assign neg_x = GRAD_W'(taps_ff[0][0]) + GRAD_W'({taps_ff[1][0], 1'b0})
                  + GRAD_W'(taps_ff[2][0]);
   assign pos_y = GRAD_W'(taps_ff[2][0]) + GRAD_W'({taps_ff[2][1], 1'b0})
                  + GRAD_W'(taps_ff[2][2]);
   assign neg_y = GRAD_W'(taps_ff[0][0]) + GRAD_W'({taps_ff[0][1], 1'b0})
                  + GRAD_W'(taps_ff[0][2]);

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         gx_ff <= signed'(pos_x - neg_x);
         gy_ff <= signed'(pos_y - neg_y);
      end
   end

   // one shared squarer for gx then gy
   assign sq_op   = cmd.sq_x ? (2*GRAD_W)'(gx_ff) : (2*GRAD_W)'(gy_ff);
   assign sq_prod = sq_op * sq_op;

   assign trial    = root_ff | (MAG_W'(1) << cmd.root_bit);
   assign trial_sq = (2*MAG_W)'(trial) * (2*MAG_W)'(trial);

   always_ff @(posedge clock) begin
      if (cmd.sq_x) begin
         sum_ff <= SUM_W'(sq_prod);
      end else if (cmd.sq_y) begin
         sum_ff <= sum_ff + SUM_W'(sq_prod);
      end
      if (cmd.sq_y) begin
         root_ff <= '0;
      end else if (cmd.root_step && (SUM_W'(trial_sq) <= sum_ff)) begin
         root_ff <= trial;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         mag_ff      <= (sum_ff >= SUM_W'(SAT_LIMIT)) ? MAG_MAX : root_ff;
         row_out_ff  <= OUT_ROW_W'(irow_ff - RW'(1));
         col_out_ff  <= OUT_COL_W'(icol_ff - CW'(1));
         last_out_ff <= ilast_ff;
      end
   end

   assign item_emit      = emit_ff;
   assign edge_magnitude = mag_ff;
   assign out_row        = row_out_ff;
   assign out_col        = col_out_ff;
   assign frame_last     = last_out_ff;

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      col_ff <= last_col)
      else $error("column counter beyond the last column");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_ff <= last_row)
      else $error("row counter beyond the last row");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.sq_y) |-> (sum_ff <= SUM_W'(SUM_MAX)))
      else $error("gradient energy out of range");

endmodule

// File: hdl/sobel_ctrl.sv
module sobel_ctrl import sobel_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic          item_emit,
   output sobel_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT,
      S_GRAD,
      S_SQX,
      S_SQY,
      S_ROOT,
      S_LOAD
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] root_bit_ff, root_bit_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_free;

   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == S_IDLE) && req_tvalid;
      cmd.shift     = (state_ff == S_SHIFT);
      cmd.grad      = (state_ff == S_GRAD);
      cmd.sq_x      = (state_ff == S_SQX);
      cmd.sq_y      = (state_ff == S_SQY);
      cmd.root_step = (state_ff == S_ROOT);
      cmd.root_bit  = root_bit_ff;
      cmd.load_out  = (state_ff == S_LOAD) && out_free;
   end

   always_comb begin
      state_in    = state_ff;
      root_bit_in = root_bit_ff;
      case (state_ff)
         S_IDLE:  if (req_tvalid) state_in = S_SHIFT;
         // border pixels only update the window
         S_SHIFT: state_in = item_emit ? S_GRAD : S_IDLE;
         S_GRAD:  state_in = S_SQX;
         S_SQX:   state_in = S_SQY;
         S_SQY: begin
            state_in    = S_ROOT;
            root_bit_in = STEP_W'(ROOT_STEPS - 1);
         end
         S_ROOT: begin
            if (root_bit_ff == '0) begin
               state_in = S_LOAD;
            end else begin
               root_bit_in = root_bit_ff - STEP_W'(1);
            end
         end
         S_LOAD:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         root_bit_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         root_bit_ff  <= root_bit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_tready))
      else $error("result register loaded while a result is pending");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second pixel taken while one is in work");

   a_load_only_interior: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> item_emit)
      else $error("result produced for a border pixel");

endmodule

// File: hdl/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster stream of 8-bit grey pixels. Frame size comes
// from csr index 0 (width, held in 3..MAX_WIDTH) and index 1 (height, held in 3..MAX_HEIGHT);
// any csr write restarts the frame at row 0, column 0. One result per interior pixel, tagged
// with its row and column, tlast on the last interior pixel of the frame; border pixels give
// none. A border pixel takes a line store read and a window shift; an interior pixel takes
// the read, the shift, gradients, the shared squarer for gx then for gy and the bit-per-cycle
// square root unit, then a load into the output register, which waits while the previous
// result is still held there. The output register lets the next pixel be taken while a result
// still waits on rsp_tready. Line stores are not cleared; stale contents reach only the
// windows of rows 0 and 1 of a frame, which give no result.
module sobel_edge_magnitude import sobel_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [7:0] pixel_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [7:0] edge_magnitude, [19:8] out_row,
                                              // [30:20] out_col, [31] zero
   output logic                   rsp_tlast   // frame_last
);

   sobel_cmd_type         cmd;
   logic                  item_emit;
   logic [MAG_W-1:0]      edge_magnitude;
   logic [OUT_ROW_W-1:0]  out_row;
   logic [OUT_COL_W-1:0]  out_col;

   sobel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .item_emit  (item_emit),
      .cmd        (cmd)
   );

   sobel_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .pixel_value    (req_tdata[PIXEL_W-1:0]),
      .cmd            (cmd),
      .item_emit      (item_emit),
      .edge_magnitude (edge_magnitude),
      .out_row        (out_row),
      .out_col        (out_col),
      .frame_last     (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_col, out_row, edge_magnitude};

endmodule
